FILE: rtl/core/afc_pkg.sv
// Shared constants for the box frustum culling block.
package afc_pkg;

  localparam int MAT_W        = 32;
  localparam int NUM_PAIRS    = 8;
  localparam int NUM_ENTRIES  = 16;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int NUM_CORNERS  = 8;
  localparam int NUM_ROWS     = 4;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Row of the clip-space vector that holds w.
  localparam int ROW_W = 3;

  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  // Reset gives the identity matrix.
  function automatic cfg_word_t pair_reset(input int k);
    cfg_word_t v;
    v = '0;
    if (k == 0 || k == 5) v = cfg_word_t'(64'd65536);
    if (k == 2 || k == 7) v = cfg_word_t'(64'd1) << 48;
    return v;
  endfunction

endpackage

FILE: rtl/core/aabb_frustum_cull.sv
// Top level of the box frustum culling pipeline.
// Takes one box per cycle while the output side does not stall and returns one visible flag per
// box. The rate is set by the 24 parallel multipliers (matrix entry times each of the six box
// bounds per row) of stage 1, after the input register; the corner sums, the plane comparisons
// and the output register follow in their own stages. Stalls ripple back stage by stage, so empty
// stages fill up while the output waits. The user must write the matrix through the cfg port only
// while the pipeline holds no box; the block itself does not enforce this.
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_idx,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_visible
);

  localparam int PW = MAT_W + COORD_WIDTH;
  localparam int TW = MAT_W + FRAC_BITS + 1;
  localparam int SW = ((PW > TW) ? PW : TW) + 2;

  // Matrix registers.
  logic [CFG_DATA_W-1:0] mat_r [NUM_PAIRS];
  logic signed [MAT_W-1:0] ent [NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PAIRS; k++) mat_r[k] <= pair_reset(k);
    end else if (cfg_we && cfg_idx < CFG_IDX_W'(NUM_PAIRS)) begin
      mat_r[cfg_idx[$clog2(NUM_PAIRS)-1:0]] <= cfg_data;
    end
  end

  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_ent
    assign ent[e] = mat_r[e/2][(e%2)*MAT_W +: MAT_W];
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic en0, en1, en2, en3, en4;

  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 0: input register, bounds indexed [axis][min/max].
  logic signed [COORD_WIDTH-1:0] crd_r [3][2];

  always_ff @(posedge clk) begin
    if (en0) begin
      crd_r[0][0] <= in_box_min_x;
      crd_r[1][0] <= in_box_min_y;
      crd_r[2][0] <= in_box_min_z;
      crd_r[0][1] <= in_box_max_x;
      crd_r[1][1] <= in_box_max_y;
      crd_r[2][1] <= in_box_max_z;
    end
  end

  // Stage 1: one product per row, axis and bound.
  logic signed [PW-1:0] prod_r [NUM_ROWS][3][2];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_mul_r
    for (genvar a = 0; a < 3; a++) begin : g_mul_a
      for (genvar s = 0; s < 2; s++) begin : g_mul_s
        logic signed [PW-1:0] m_ext, c_ext;
        assign m_ext = PW'(ent[r + 4*a]);
        assign c_ext = PW'(crd_r[a][s]);
        always_ff @(posedge clk) begin
          if (en1) prod_r[r][a][s] <= m_ext * c_ext;
        end
      end
    end
  end

  // Stage 2: x+y for the four x/y choices, z plus translation for the two z choices.
  logic signed [SW-1:0] xy_r [NUM_ROWS][4];
  logic signed [SW-1:0] zt_r [NUM_ROWS][2];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_sum2
    logic signed [SW-1:0] trans;
    assign trans = SW'(ent[r + 12]) <<< FRAC_BITS;
    for (genvar q = 0; q < 4; q++) begin : g_xy
      always_ff @(posedge clk) begin
        if (en2) xy_r[r][q] <= SW'(prod_r[r][0][q/2]) + SW'(prod_r[r][1][q%2]);
      end
    end
    for (genvar s = 0; s < 2; s++) begin : g_zt
      always_ff @(posedge clk) begin
        if (en2) zt_r[r][s] <= SW'(prod_r[r][2][s]) + trans;
      end
    end
  end

  // Stage 3: clip coordinates of each corner; corner bit 2 picks x, bit 1 y, bit 0 z.
  logic signed [SW-1:0] clip_r [NUM_ROWS][NUM_CORNERS];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_clip_r
    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_clip_c
      always_ff @(posedge clk) begin
        if (en3) clip_r[r][c] <= xy_r[r][c/2] + zt_r[r][c%2];
      end
    end
  end

  // Stage 4: plane tests and the result register.
  logic [NUM_CORNERS-1:0] behind;
  logic [5:0] outside [NUM_CORNERS];
  logic [5:0] cull;
  logic visible_nxt;
  logic vis_r;

  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_test
    logic signed [SW-1:0] w;
    assign w = clip_r[ROW_W][c];
    assign behind[c] = w[SW-1] || (w == '0);
    for (genvar r = 0; r < 3; r++) begin : g_pl
      logic signed [SW:0] lo_sum, hi_dif;
      // v < -w is v + w < 0; v > w is w - v < 0.
      assign lo_sum = (SW+1)'(clip_r[r][c]) + (SW+1)'(w);
      assign hi_dif = (SW+1)'(w) - (SW+1)'(clip_r[r][c]);
      assign outside[c][2*r]   = lo_sum[SW];
      assign outside[c][2*r+1] = hi_dif[SW];
    end
  end

  always_comb begin
    cull = '1;
    for (int c = 0; c < NUM_CORNERS; c++) cull = cull & outside[c];
    visible_nxt = (|behind) || !(|cull);
  end

  always_ff @(posedge clk) begin
    if (en4) vis_r <= visible_nxt;
  end

  assign out_valid   = v4_r;
  assign out_visible = vis_r;

  // A box that leaves the last compute stage shows up as a result.
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en4) |=> out_valid)
    else $error("result lost between last stage and output");

  // An accepted box lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v0_r)
    else $error("accepted item not captured");

  // Input stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v0_r && v1_r && v2_r && v3_r && v4_r))
    else $error("input stalled with an empty stage");

  // A write to the first matrix pair is stored.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_idx == '0) |=> (mat_r[0] == $past(cfg_data)))
    else $error("matrix write not stored");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the box frustum culling pipeline: predicted visible flags vs. DUT.
`timescale 1ns / 1ps

module tb_top
  import afc_pkg::*;
();

  localparam int ONE  = 1 << FRAC_BITS_DEF;
  localparam int CMAX = 2147483647;
  localparam int CMIN = -2147483647 - 1;
  localparam int WIDE = 1 << 30;

  typedef logic signed [COORD_WIDTH_DEF-1:0] coord_t;
  typedef logic signed [95:0] acc_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_box_min_x = '0;
  coord_t in_box_min_y = '0;
  coord_t in_box_min_z = '0;
  coord_t in_box_max_x = '0;
  coord_t in_box_max_y = '0;
  coord_t in_box_max_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_visible;

  cfg_word_t view_proj [NUM_PAIRS];
  box_t box_queue [$];
  logic visible_pending [$];
  box_t shown_box;
  bit box_taken = 1'b0;
  bit failed = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int calm_left [2] = '{0, 0};

  aabb_frustum_cull dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_box_min_x(in_box_min_x),
    .in_box_min_y(in_box_min_y),
    .in_box_min_z(in_box_min_z),
    .in_box_max_x(in_box_max_x),
    .in_box_max_y(in_box_max_y),
    .in_box_max_z(in_box_max_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_visible (out_visible)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic acc_t matrix_entry(int e);
    logic signed [MAT_W-1:0] raw;
    acc_t wide;
    raw = view_proj[e / 2][(e % 2) * MAT_W +: MAT_W];
    wide = raw;
    return wide;
  endfunction

  // One row of the matrix applied to the point (x, y, z, 1), kept exact.
  function automatic acc_t clip_component(int row, coord_t x, coord_t y, coord_t z);
    acc_t ax, ay, az;
    ax = x;
    ay = y;
    az = z;
    return matrix_entry(row) * ax + matrix_entry(row + 4) * ay
         + matrix_entry(row + 8) * az + (matrix_entry(row + 12) <<< FRAC_BITS_DEF);
  endfunction

  function automatic logic box_visible(box_t b);
    logic [5:0] all_out;
    coord_t x, y, z;
    acc_t w, v;
    int c, r;
    all_out = '1;
    for (c = 0; c < NUM_CORNERS; c++) begin
      x = ((c & 4) != 0) ? b.hi_x : b.lo_x;
      y = ((c & 2) != 0) ? b.hi_y : b.lo_y;
      z = ((c & 1) != 0) ? b.hi_z : b.lo_z;
      w = clip_component(ROW_W, x, y, z);
      // A corner at or behind the eye makes the plane tests meaningless.
      if (w <= 0) return 1'b1;
      for (r = 0; r < ROW_W; r++) begin
        v = clip_component(r, x, y, z);
        if (v >= -w) all_out[2 * r] = 1'b0;
        if (v <= w) all_out[2 * r + 1] = 1'b0;
      end
    end
    return (all_out == 6'b0);
  endfunction

  // Idle length for the sender (side 0) or the receiver (side 1).
  function automatic int idle_len(int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side] = calm_left[side] - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo_x = lx;
    b.lo_y = ly;
    b.lo_z = lz;
    b.hi_x = hx;
    b.hi_y = hy;
    b.hi_z = hz;
    return b;
  endfunction

  // Mostly well-formed boxes around the view volume, some with swapped bounds,
  // some with every bit random.
  function automatic box_t random_box(int span, int z_shift);
    coord_t lo [3];
    coord_t hi [3];
    coord_t t;
    int ctr, half, a, r;
    r = $urandom_range(0, 9);
    for (a = 0; a < 3; a++) begin
      ctr = int'($urandom_range(0, 2 * span)) - span;
      half = $urandom_range(0, span / 2);
      if (a == 2) ctr = ctr + z_shift;
      lo[a] = ctr - half;
      hi[a] = ctr + half;
      if (r == 0) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end
    end
    if (r == 1) begin
      a = $urandom_range(0, 2);
      t = lo[a];
      lo[a] = hi[a];
      hi[a] = t;
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic send_random(int count, int span, int z_shift);
    repeat (count) box_queue.push_back(random_box(span, z_shift));
  endtask

  task automatic wait_idle();
    while (box_queue.size() != 0 || in_valid || visible_pending.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pair(int idx, cfg_word_t data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx[CFG_IDX_W-1:0];
    cfg_data <= data;
    if (idx < NUM_PAIRS) view_proj[idx] = data;
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_uniform(cfg_word_t data);
    int k;
    for (k = 0; k < NUM_PAIRS; k++) write_pair(k, data);
    close_writes();
  endtask

  // Small entries for x, y, z and a w row that is usually positive near the origin.
  task automatic load_random_matrix();
    logic signed [MAT_W-1:0] ent [NUM_ENTRIES];
    int e;
    for (e = 0; e < NUM_ENTRIES; e++) begin
      if (e == NUM_ENTRIES - 1) ent[e] = $urandom_range(ONE / 2, 4 * ONE);
      else if (e % NUM_ROWS == ROW_W) ent[e] = int'($urandom_range(0, ONE)) - ONE / 2;
      else ent[e] = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
    end
    for (e = 0; e < NUM_PAIRS; e++) write_pair(e, {ent[2 * e + 1], ent[2 * e]});
    close_writes();
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || box_taken) begin
      box_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (box_queue.size() > 0) begin
        shown_box = box_queue.pop_front();
        in_box_min_x <= shown_box.lo_x;
        in_box_min_y <= shown_box.lo_y;
        in_box_min_z <= shown_box.lo_z;
        in_box_max_x <= shown_box.hi_x;
        in_box_max_y <= shown_box.hi_y;
        in_box_max_z <= shown_box.hi_z;
        in_valid <= 1'b1;
        in_gap = idle_len(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_len(1);
    end
  end

  always @(posedge clk) begin
    logic want;
    if (rst_n && in_valid && !in_stall) begin
      visible_pending.push_back(box_visible(shown_box));
      box_taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (visible_pending.size() == 0) begin
        $display("%0t: visible result with none expected, actual %0b", $time, out_visible);
        failed = 1'b1;
      end else begin
        want = visible_pending.pop_front();
        if (out_visible !== want) begin
          $display("%0t: visible mismatch, expected %0b, actual %0b", $time, want,
                   out_visible);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < NUM_PAIRS; k++) view_proj[k] = '0;
    view_proj[0] = 64'd65536;
    view_proj[2] = 64'd1 << 48;
    view_proj[5] = 64'd65536;
    view_proj[7] = 64'd1 << 48;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Identity matrix: the view volume is the cube from -1 to 1.
    box_queue.push_back(mk_box(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2));
    box_queue.push_back(mk_box(3 * ONE / 2, 0, 0, 2 * ONE, ONE / 2, ONE / 2));
    box_queue.push_back(mk_box(-3 * ONE, 0, 0, -2 * ONE, ONE / 2, ONE / 2));
    box_queue.push_back(mk_box(0, 3 * ONE / 2, 0, ONE / 2, 2 * ONE, ONE / 2));
    box_queue.push_back(mk_box(0, -3 * ONE, 0, ONE / 2, -2 * ONE, ONE / 2));
    box_queue.push_back(mk_box(0, 0, 3 * ONE / 2, ONE / 2, ONE / 2, 2 * ONE));
    box_queue.push_back(mk_box(0, 0, -3 * ONE, ONE / 2, ONE / 2, -2 * ONE));
    // A corner exactly on a plane does not count as outside it.
    box_queue.push_back(mk_box(ONE, -ONE / 2, -ONE / 2, 2 * ONE, ONE / 2, ONE / 2));
    box_queue.push_back(mk_box(ONE + 1, -ONE / 2, -ONE / 2, 2 * ONE, ONE / 2, ONE / 2));
    // Swapped bounds are used as given.
    box_queue.push_back(mk_box(2 * ONE, 0, 0, -2 * ONE, ONE / 2, ONE / 2));
    box_queue.push_back(mk_box(3 * ONE, 0, 0, 2 * ONE, ONE / 2, ONE / 2));
    box_queue.push_back(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    box_queue.push_back(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    box_queue.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    box_queue.push_back(mk_box(0, 0, 0, 0, 0, 0));
    send_random(100, 3 * ONE, 0);

    // Writes to indexes past the last pair must leave the matrix alone.
    wait_idle();
    for (k = NUM_PAIRS; k < (1 << CFG_IDX_W); k++) write_pair(k, {$urandom, $urandom});
    close_writes();
    send_random(50, 3 * ONE, 0);

    // Perspective: w = -z, near plane at z = -0.5, looking down -z.
    wait_idle();
    write_pair(0, 64'h0000_0000_0001_0000);
    write_pair(1, 64'h0);
    write_pair(2, 64'h0001_0000_0000_0000);
    write_pair(3, 64'h0);
    write_pair(4, 64'h0);
    write_pair(5, 64'hFFFF_0000_FFFF_0000);
    write_pair(6, 64'h0);
    write_pair(7, 64'h0000_0000_FFFF_0000);
    close_writes();
    box_queue.push_back(mk_box(-ONE / 100, -ONE / 100, -ONE * 2 / 5,
                               ONE / 100, ONE / 100, -ONE / 10));
    box_queue.push_back(mk_box(-ONE, -ONE, -5 * ONE, ONE, ONE, -2 * ONE));
    box_queue.push_back(mk_box(-ONE, -ONE, -3 * ONE, ONE, ONE, 2 * ONE));
    // Far off to the side, but one corner sits exactly at w = 0.
    box_queue.push_back(mk_box(100 * ONE, -ONE, -3 * ONE, 200 * ONE, ONE, 0));
    box_queue.push_back(mk_box(10 * ONE, -ONE, -3 * ONE, 20 * ONE, ONE, -2 * ONE));
    send_random(130, 4 * ONE, -4 * ONE);

    repeat (4) begin
      wait_idle();
      load_random_matrix();
      send_random(50, 3 * ONE, 0);
    end

    wait_idle();
    load_uniform(64'hFFFF_FFFF_FFFF_FFFF);
    send_random(25, WIDE, 0);
    wait_idle();
    load_uniform(64'h0);
    send_random(15, WIDE, 0);
    wait_idle();
    load_uniform(64'h7FFF_FFFF_8000_0000);
    send_random(25, WIDE, 0);

    wait_idle();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
